[hdl/virtio_pci_common_config_regs_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the virtio PCI register block
// Same-cycle and next-cycle implication checks, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef VIRTIO_PCI_COMMON_CONFIG_REGS_DEFINES_SVH
`define VIRTIO_PCI_COMMON_CONFIG_REGS_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VPCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define VPCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/vpcc_pkg.sv]
// ----------------------------------------------------------------------------
// vpcc_pkg
// Shared codes, offsets, reset values and item types of the virtio PCI
// register block.
// ----------------------------------------------------------------------------
package vpcc_pkg;

	// Default parameter values
	localparam int unsigned MAX_QUEUES_DEF      = 8;
	localparam int unsigned DEV_CFG_BYTES_DEF   = 256;

	// Access kinds
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Regions
	localparam logic [1:0] REGION_COMMON = 2'd0;
	localparam logic [1:0] REGION_NOTIFY = 2'd1;
	localparam logic [1:0] REGION_ISR    = 2'd2;
	localparam logic [1:0] REGION_DEVICE = 2'd3;

	// Outcome codes
	localparam logic [1:0] OUT_OK          = 2'd0;
	localparam logic [1:0] OUT_UNSUPPORTED = 2'd1;
	localparam logic [1:0] OUT_SIZE        = 2'd2;
	localparam logic [1:0] OUT_RANGE       = 2'd3;

	// Access sizes
	localparam logic [2:0] SIZE_1 = 3'd1;
	localparam logic [2:0] SIZE_2 = 3'd2;
	localparam logic [2:0] SIZE_4 = 3'd4;

	// Common config offsets
	localparam logic [7:0] OFF_DEV_FEAT_SEL   = 8'd0;
	localparam logic [7:0] OFF_DEV_FEAT       = 8'd4;
	localparam logic [7:0] OFF_GUEST_FEAT_SEL = 8'd8;
	localparam logic [7:0] OFF_GUEST_FEAT     = 8'd12;
	localparam logic [7:0] OFF_NUM_QUEUES     = 8'd18;
	localparam logic [7:0] OFF_DEV_STATUS     = 8'd20;
	localparam logic [7:0] OFF_CFG_GEN        = 8'd21;
	localparam logic [7:0] OFF_QUEUE_SEL      = 8'd22;
	localparam logic [7:0] OFF_QUEUE_SIZE     = 8'd24;
	localparam logic [7:0] OFF_QUEUE_ENABLE   = 8'd28;
	localparam logic [7:0] OFF_QUEUE_NOTIFY   = 8'd30;

	// Configuration register indexes
	localparam logic [1:0] CFG_OFFERED_FEATURES = 2'd0;
	localparam logic [1:0] CFG_QUEUE_COUNT      = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_QSIZE    = 2'd2;
	localparam logic [1:0] CFG_DEV_CFG_LEN      = 2'd3;

	// Configuration reset values
	localparam logic [63:0] OFFERED_FEATURES_RST = 64'h0000_0001_2000_0000;
	localparam logic [3:0]  QUEUE_COUNT_RST      = 4'd1;
	localparam logic [15:0] DEFAULT_QSIZE_RST    = 16'h0100;
	localparam logic [8:0]  DEV_CFG_LEN_RST      = 9'd256;

	// Feature bits
	localparam int unsigned BIT_VERSION_1 = 32;
	localparam int unsigned BIT_EVENT_IDX = 29;
	localparam logic [63:0] FEAT_FORCED   = 64'h0000_0001_2000_0000;
	localparam int unsigned STATUS_FEATURES_OK_BIT = 3;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  region;
		logic [7:0]  offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  outcome;
	} result_t;

endpackage

[hdl/vpcc_common.sv]
// ----------------------------------------------------------------------------
// vpcc_common
// Common config region: decode, feature and status registers, queue tables.
// ----------------------------------------------------------------------------
module vpcc_common #(
	parameter int unsigned MAX_QUEUES = vpcc_pkg::MAX_QUEUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  vpcc_pkg::item_t   item_s1,
	input  logic [63:0]       offered_features,
	input  logic [3:0]        queue_count,
	input  logic [15:0]       default_queue_size,
	output vpcc_pkg::result_t result
);

	localparam int unsigned QIW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int unsigned LQW = $clog2(MAX_QUEUES + 1);

	logic              dev_hi_q;
	logic              guest_hi_q;
	logic [63:0]       accepted_q;
	logic [7:0]        status_q;
	logic [15:0]       sel_q;
	logic [15:0]       qsize_q    [MAX_QUEUES];
	logic              qsize_wr_q [MAX_QUEUES];
	logic [15:0]       qen_q      [MAX_QUEUES];

	logic [LQW-1:0]    live;
	logic [QIW-1:0]    q_idx;
	logic              in_range;
	logic [63:0]       feat;
	logic              known;
	logic              qfield;
	logic [2:0]        need;
	logic [1:0]        outcome;
	logic [31:0]       rdata;
	logic              commit;
	logic [7:0]        status_nxt;

	assign live = (32'(queue_count) < MAX_QUEUES) ? LQW'(queue_count) : LQW'(MAX_QUEUES);
	assign q_idx    = QIW'(sel_q);
	assign in_range = sel_q < 16'(live);
	assign feat     = offered_features | vpcc_pkg::FEAT_FORCED;

	// Decode the offset: which fields exist and at what width
	always_comb begin
		known  = 1'b1;
		qfield = 1'b0;
		need   = vpcc_pkg::SIZE_4;
		if (item_s1.cmd == vpcc_pkg::CMD_READ) begin
			unique case (item_s1.offset)
				vpcc_pkg::OFF_DEV_FEAT:     need = vpcc_pkg::SIZE_4;
				vpcc_pkg::OFF_NUM_QUEUES:   need = vpcc_pkg::SIZE_2;
				vpcc_pkg::OFF_DEV_STATUS:   need = vpcc_pkg::SIZE_1;
				vpcc_pkg::OFF_CFG_GEN:      need = vpcc_pkg::SIZE_1;
				vpcc_pkg::OFF_QUEUE_SIZE,
				vpcc_pkg::OFF_QUEUE_ENABLE,
				vpcc_pkg::OFF_QUEUE_NOTIFY: begin
					need   = vpcc_pkg::SIZE_2;
					qfield = 1'b1;
				end
				default:                    known = 1'b0;
			endcase
		end else begin
			unique case (item_s1.offset)
				vpcc_pkg::OFF_DEV_FEAT_SEL,
				vpcc_pkg::OFF_GUEST_FEAT_SEL,
				vpcc_pkg::OFF_GUEST_FEAT:   need = vpcc_pkg::SIZE_4;
				vpcc_pkg::OFF_DEV_STATUS:   need = vpcc_pkg::SIZE_1;
				vpcc_pkg::OFF_QUEUE_SEL:    need = vpcc_pkg::SIZE_2;
				vpcc_pkg::OFF_QUEUE_SIZE,
				vpcc_pkg::OFF_QUEUE_ENABLE: begin
					need   = vpcc_pkg::SIZE_2;
					qfield = 1'b1;
				end
				default:                    known = 1'b0;
			endcase
		end

		if (!known) begin
			outcome = vpcc_pkg::OUT_UNSUPPORTED;
		end else if (item_s1.access_size != need) begin
			outcome = vpcc_pkg::OUT_SIZE;
		end else if (qfield && !in_range) begin
			outcome = vpcc_pkg::OUT_RANGE;
		end else begin
			outcome = vpcc_pkg::OUT_OK;
		end
	end

	// Read data; config generation falls through to zero
	always_comb begin
		unique case (item_s1.offset)
			vpcc_pkg::OFF_DEV_FEAT:     rdata = dev_hi_q ? feat[63:32] : feat[31:0];
			vpcc_pkg::OFF_NUM_QUEUES:   rdata = 32'(live);
			vpcc_pkg::OFF_DEV_STATUS:   rdata = 32'(status_q);
			vpcc_pkg::OFF_QUEUE_SIZE:
				rdata = qsize_wr_q[q_idx] ? 32'(qsize_q[q_idx]) : 32'(default_queue_size);
			vpcc_pkg::OFF_QUEUE_ENABLE: rdata = 32'(qen_q[q_idx]);
			vpcc_pkg::OFF_QUEUE_NOTIFY: rdata = 32'(sel_q);
			default:                    rdata = '0;
		endcase
	end

	assign result.read_data = rdata;
	assign result.outcome   = outcome;

	assign commit = valid_s1 && (item_s1.region == vpcc_pkg::REGION_COMMON)
		&& (item_s1.cmd == vpcc_pkg::CMD_WRITE) && (outcome == vpcc_pkg::OUT_OK);

	// Drop FEATURES_OK unless both required features were accepted
	always_comb begin
		status_nxt = item_s1.write_data[7:0];
		if (!(accepted_q[vpcc_pkg::BIT_VERSION_1] && accepted_q[vpcc_pkg::BIT_EVENT_IDX])) begin
			status_nxt[vpcc_pkg::STATUS_FEATURES_OK_BIT] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_hi_q   <= 1'b0;
			guest_hi_q <= 1'b0;
			accepted_q <= '0;
			status_q   <= '0;
			sel_q      <= '0;
			for (int q = 0; q < MAX_QUEUES; q++) begin
				qsize_wr_q[q] <= 1'b0;
				qen_q[q]      <= '0;
			end
		end else if (commit) begin
			unique case (item_s1.offset)
				vpcc_pkg::OFF_DEV_FEAT_SEL:   dev_hi_q   <= item_s1.write_data != '0;
				vpcc_pkg::OFF_GUEST_FEAT_SEL: guest_hi_q <= item_s1.write_data != '0;
				vpcc_pkg::OFF_GUEST_FEAT: begin
					if (guest_hi_q) begin
						accepted_q[63:32] <= item_s1.write_data;
					end else begin
						accepted_q[31:0] <= item_s1.write_data;
					end
				end
				vpcc_pkg::OFF_DEV_STATUS:     status_q <= status_nxt;
				vpcc_pkg::OFF_QUEUE_SEL:      sel_q    <= item_s1.write_data[15:0];
				vpcc_pkg::OFF_QUEUE_SIZE:     qsize_wr_q[q_idx] <= 1'b1;
				vpcc_pkg::OFF_QUEUE_ENABLE:   qen_q[q_idx] <= item_s1.write_data[15:0];
				default: ;
			endcase
		end
	end

	// Queue sizes hold no reset value; the written flag covers them
	always_ff @(posedge clk) begin
		if (commit && (item_s1.offset == vpcc_pkg::OFF_QUEUE_SIZE)) begin
			qsize_q[q_idx] <= item_s1.write_data[15:0];
		end
	end

endmodule

[hdl/vpcc_devcfg.sv]
// ----------------------------------------------------------------------------
// vpcc_devcfg
// Device config byte store: four byte-lane banks, a clearing pass after
// reset, range check and read assembly.
// ----------------------------------------------------------------------------
`include "virtio_pci_common_config_regs_defines.svh"

module vpcc_devcfg #(
	parameter int unsigned DEVICE_CONFIG_BYTES = vpcc_pkg::DEV_CFG_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  vpcc_pkg::item_t   item,
	input  vpcc_pkg::item_t   item_s1,
	input  logic [8:0]        config_len,
	output logic              busy,
	output vpcc_pkg::result_t result
);

	localparam int unsigned ROWS = (DEVICE_CONFIG_BYTES + 3) / 4;
	localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic          clearing_q;
	logic [RW-1:0] clr_q;
	logic [8:0]    live_len;
	logic [8:0]    end_addr;
	logic          size_ok;
	logic [1:0]    outcome_now;
	logic [1:0]    outcome_s1;
	logic          we;
	logic [7:0]    lane_rd_s1 [4];

	assign busy = clearing_q;

	assign live_len = (32'(config_len) < DEVICE_CONFIG_BYTES) ? config_len
		: 9'(DEVICE_CONFIG_BYTES);
	assign end_addr = {1'b0, item.offset} + 9'(item.access_size);
	assign size_ok  = (item.access_size == vpcc_pkg::SIZE_1)
		|| (item.access_size == vpcc_pkg::SIZE_2)
		|| (item.access_size == vpcc_pkg::SIZE_4);

	always_comb begin
		if (!size_ok) begin
			outcome_now = vpcc_pkg::OUT_SIZE;
		end else if (end_addr > live_len) begin
			outcome_now = vpcc_pkg::OUT_RANGE;
		end else begin
			outcome_now = vpcc_pkg::OUT_OK;
		end
	end

	assign we = accept && (item.region == vpcc_pkg::REGION_DEVICE)
		&& (item.cmd == vpcc_pkg::CMD_WRITE) && (outcome_now == vpcc_pkg::OUT_OK);

	always_ff @(posedge clk) begin
		if (accept) begin
			outcome_s1 <= outcome_now;
		end
	end

	// Sweep one row per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == RW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + RW'(1);
			end
		end
	end

	// Lane k holds bytes whose address is k modulo four
	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [1:0]    idx;
		logic [8:0]    addr;
		logic [RW-1:0] row;
		logic          used;
		logic [7:0]    mem [ROWS];

		assign idx  = 2'(k) - item.offset[1:0];
		assign addr = {1'b0, item.offset} + 9'(idx);
		assign row  = RW'(addr >> 2);
		assign used = {1'b0, idx} < item.access_size;

		always_ff @(posedge clk) begin
			if (clearing_q) begin
				mem[clr_q] <= '0;
			end else if (we && used) begin
				mem[row] <= item.write_data[{idx, 3'b000} +: 8];
			end
		end

		always_ff @(posedge clk) begin
			if (accept) begin
				lane_rd_s1[k] <= mem[row];
			end
		end
	end

	// Rotate lanes back into byte order and mask unused bytes
	always_comb begin
		logic [1:0] lane;
		result.read_data = '0;
		result.outcome   = outcome_s1;
		for (int i = 0; i < 4; i++) begin
			lane = item_s1.offset[1:0] + 2'(i);
			if (3'(i) < item_s1.access_size) begin
				result.read_data[8*i +: 8] = lane_rd_s1[lane];
			end
		end
	end

	`VPCC_ASSERT_NEXT(a_clear_once, clk, arst_n, !busy, !busy, "store busy again after clear")

endmodule

[hdl/virtio_pci_common_config_regs.sv]
// ----------------------------------------------------------------------------
// virtio_pci_common_config_regs
// Virtio 1.0 PCI register block: common config, notify, ISR and device
// config regions, one bus access in and one result out per access.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an access on cmd/region/offset/access_size/write_data with start
//   high; the item is taken at a rising edge where start is high and busy is
//   low. After the input register and the result register, done is high for
//   one cycle with read_data and outcome; the receiver cannot stall, so
//   take the result then. A new item may be started every cycle while busy
//   is low: the input register, the decode stage and the result register
//   overlap, so throughput is one item per cycle when busy is low.
//   Device config reads and writes use four byte-lane memories addressed at
//   the accept edge; common region state updates in the cycle after, from
//   the input register, so each item sees everything earlier items left.
//   After reset busy stays high while the device store is swept to zero,
//   one row per cycle over ceil(DEVICE_CONFIG_BYTES / 4) rows (64 at the
//   default size); configuration writes are taken during that time.
//   Configuration goes through cfg_we/cfg_index/cfg_wdata. The user must
//   write it only while no access is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "virtio_pci_common_config_regs_defines.svh"

module virtio_pci_common_config_regs #(
	parameter int unsigned MAX_QUEUES          = vpcc_pkg::MAX_QUEUES_DEF,
	parameter int unsigned DEVICE_CONFIG_BYTES = vpcc_pkg::DEV_CFG_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// access channel
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [1:0]  region,
	input  logic [7:0]  offset,
	input  logic [2:0]  access_size,
	input  logic [31:0] write_data,
	// result channel
	output logic        done,
	output logic [31:0] read_data,
	output logic [1:0]  outcome,
	// configuration port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic              accept;
	vpcc_pkg::item_t   item;
	vpcc_pkg::item_t   item_s1;
	logic              valid_s1;
	vpcc_pkg::result_t common_res;
	vpcc_pkg::result_t dev_res;
	vpcc_pkg::result_t res;

	logic [63:0]       offered_features_q;
	logic [3:0]        queue_count_q;
	logic [15:0]       default_qsize_q;
	logic [8:0]        dev_cfg_len_q;

	logic              done_q;
	logic [31:0]       read_data_q;
	logic [1:0]        outcome_q;

	assign accept = start && !busy;

	assign item.cmd         = cmd;
	assign item.region      = region;
	assign item.offset      = offset;
	assign item.access_size = access_size;
	assign item.write_data  = write_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offered_features_q <= vpcc_pkg::OFFERED_FEATURES_RST;
			queue_count_q      <= vpcc_pkg::QUEUE_COUNT_RST;
			default_qsize_q    <= vpcc_pkg::DEFAULT_QSIZE_RST;
			dev_cfg_len_q      <= vpcc_pkg::DEV_CFG_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vpcc_pkg::CFG_OFFERED_FEATURES: offered_features_q <= cfg_wdata;
				vpcc_pkg::CFG_QUEUE_COUNT:      queue_count_q      <= cfg_wdata[3:0];
				vpcc_pkg::CFG_DEFAULT_QSIZE:    default_qsize_q    <= cfg_wdata[15:0];
				vpcc_pkg::CFG_DEV_CFG_LEN:      dev_cfg_len_q      <= cfg_wdata[8:0];
			endcase
		end
	end

	// Input register: hold the accepted item for the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	vpcc_common #(
		.MAX_QUEUES (MAX_QUEUES)
	) u_common (
		.clk                (clk),
		.arst_n             (arst_n),
		.valid_s1           (valid_s1),
		.item_s1            (item_s1),
		.offered_features   (offered_features_q),
		.queue_count        (queue_count_q),
		.default_queue_size (default_qsize_q),
		.result             (common_res)
	);

	vpcc_devcfg #(
		.DEVICE_CONFIG_BYTES (DEVICE_CONFIG_BYTES)
	) u_devcfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.item_s1    (item_s1),
		.config_len (dev_cfg_len_q),
		.busy       (busy),
		.result     (dev_res)
	);

	// Pick the region's answer; notify and ISR are never served
	always_comb begin
		unique case (item_s1.region)
			vpcc_pkg::REGION_COMMON: res = common_res;
			vpcc_pkg::REGION_DEVICE: res = dev_res;
			default: begin
				res.read_data = '0;
				res.outcome   = vpcc_pkg::OUT_UNSUPPORTED;
			end
		endcase
	end

	// Result register: writes and failures return zero data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outcome_q <= res.outcome;
			if ((item_s1.cmd == vpcc_pkg::CMD_WRITE) || (res.outcome != vpcc_pkg::OUT_OK)) begin
				read_data_q <= '0;
			end else begin
				read_data_q <= res.read_data;
			end
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign outcome   = outcome_q;

	`VPCC_ASSERT_SAME(a_done_follows, clk, arst_n, $past(accept, 2), done, "result missing")
	`VPCC_ASSERT_SAME(a_done_cause, clk, arst_n, done, $past(accept, 2), "result invented")
	`VPCC_ASSERT_NEXT(a_write_zero, clk, arst_n, valid_s1 && (item_s1.cmd == vpcc_pkg::CMD_WRITE),
		read_data == '0, "write result carries data")

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the virtio PCI register block. Bus accesses go in
// through the start/busy handshake and are predicted in order by a local
// model of the common, notify, ISR and device regions. Every done strobe is
// checked field by field against the oldest prediction. Directed accesses
// come first, then random traffic under several register settings.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vpcc_pkg::*;

	localparam int unsigned MAX_Q      = MAX_QUEUES_DEF;
	localparam int unsigned CFG_BYTES  = DEV_CFG_BYTES_DEF;
	localparam int unsigned CYCLE_CAP  = 200000;

	// DUT inputs start at known values; all later changes are nonblocking at posedge.
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        cmd         = CMD_READ;
	logic [1:0]  region      = REGION_COMMON;
	logic [7:0]  offset      = 8'd0;
	logic [2:0]  access_size = SIZE_4;
	logic [31:0] write_data  = 32'd0;
	logic        cfg_we      = 1'b0;
	logic [1:0]  cfg_index   = CFG_OFFERED_FEATURES;
	logic [63:0] cfg_wdata   = 64'd0;

	logic        busy;
	logic        done;
	logic [31:0] read_data;
	logic [1:0]  outcome;

	virtio_pci_common_config_regs i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.region     (region),
		.offset     (offset),
		.access_size(access_size),
		.write_data (write_data),
		.done       (done),
		.read_data  (read_data),
		.outcome    (outcome),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Mirror of the configuration registers.
	logic [63:0] offered_feat;
	logic [3:0]  queue_cnt;
	logic [15:0] dflt_qsize;
	logic [8:0]  dev_cfg_len;

	// Mirror of the register block state.
	logic        dev_feat_hi;
	logic        guest_feat_hi;
	logic [63:0] guest_feat;
	logic [7:0]  dev_status;
	logic [15:0] cur_queue;
	logic [15:0] qsize_tab   [MAX_Q];
	logic        qsize_set   [MAX_Q];
	logic [15:0] qenable_tab [MAX_Q];
	logic [7:0]  dev_bytes   [CFG_BYTES];

	// Results owed by the block, oldest first.
	result_t     results_due[$];
	int          mismatches  = 0;
	int          steady_left = 0;
	int unsigned cycle_count = 0;

	// Accessible part of the device store.
	function automatic int unsigned device_window();
		return (dev_cfg_len < CFG_BYTES) ? dev_cfg_len : CFG_BYTES;
	endfunction

	// Carry out one access on the mirror state and return what the block must answer.
	function automatic result_t apply_access(input item_t it);
		result_t     r;
		logic [2:0]  need;
		logic        known;
		logic        qfield;
		int unsigned nq;
		int unsigned lim;
		int unsigned q;
		int unsigned span_end;
		logic [63:0] feat;
		logic [7:0]  st;
		r.read_data = 32'd0;
		r.outcome   = OUT_OK;
		nq          = (queue_cnt < MAX_Q) ? queue_cnt : MAX_Q;
		lim         = device_window();
		q           = 32'(cur_queue);
		case (it.region)
			REGION_COMMON: begin
				known  = 1'b1;
				qfield = 1'b0;
				need   = SIZE_4;
				if (it.cmd == CMD_READ) begin
					case (it.offset)
						OFF_DEV_FEAT:   need = SIZE_4;
						OFF_NUM_QUEUES: need = SIZE_2;
						OFF_DEV_STATUS, OFF_CFG_GEN: need = SIZE_1;
						OFF_QUEUE_SIZE, OFF_QUEUE_ENABLE, OFF_QUEUE_NOTIFY: begin
							need   = SIZE_2;
							qfield = 1'b1;
						end
						default: known = 1'b0;
					endcase
				end else begin
					case (it.offset)
						OFF_DEV_FEAT_SEL, OFF_GUEST_FEAT_SEL, OFF_GUEST_FEAT: need = SIZE_4;
						OFF_DEV_STATUS: need = SIZE_1;
						OFF_QUEUE_SEL:  need = SIZE_2;
						OFF_QUEUE_SIZE, OFF_QUEUE_ENABLE: begin
							need   = SIZE_2;
							qfield = 1'b1;
						end
						default: known = 1'b0;
					endcase
				end
				// Offset first, then width, then queue index; errors leave state alone.
				if (!known)
					r.outcome = OUT_UNSUPPORTED;
				else if (it.access_size != need)
					r.outcome = OUT_SIZE;
				else if (qfield && q >= nq)
					r.outcome = OUT_RANGE;
				else if (it.cmd == CMD_READ) begin
					case (it.offset)
						OFF_DEV_FEAT: begin
							feat        = offered_feat | FEAT_FORCED;
							r.read_data = dev_feat_hi ? feat[63:32] : feat[31:0];
						end
						OFF_NUM_QUEUES:   r.read_data = nq;
						OFF_DEV_STATUS:   r.read_data = {24'd0, dev_status};
						OFF_CFG_GEN:      r.read_data = 32'd0;
						OFF_QUEUE_SIZE:   r.read_data = {16'd0, qsize_set[q] ? qsize_tab[q] : dflt_qsize};
						OFF_QUEUE_ENABLE: r.read_data = {16'd0, qenable_tab[q]};
						default:          r.read_data = {16'd0, cur_queue};
					endcase
				end else begin
					case (it.offset)
						OFF_DEV_FEAT_SEL:   dev_feat_hi   = (it.write_data != 32'd0);
						OFF_GUEST_FEAT_SEL: guest_feat_hi = (it.write_data != 32'd0);
						OFF_GUEST_FEAT: begin
							if (guest_feat_hi)
								guest_feat[63:32] = it.write_data;
							else
								guest_feat[31:0] = it.write_data;
						end
						OFF_DEV_STATUS: begin
							// FEATURES_OK only sticks once both mandatory features are accepted.
							st = it.write_data[7:0];
							if (st[STATUS_FEATURES_OK_BIT] &&
							    !(guest_feat[BIT_VERSION_1] && guest_feat[BIT_EVENT_IDX]))
								st[STATUS_FEATURES_OK_BIT] = 1'b0;
							dev_status = st;
						end
						OFF_QUEUE_SEL: cur_queue = it.write_data[15:0];
						OFF_QUEUE_SIZE: begin
							qsize_tab[q] = it.write_data[15:0];
							qsize_set[q] = 1'b1;
						end
						default: qenable_tab[q] = it.write_data[15:0];
					endcase
				end
			end
			REGION_DEVICE: begin
				span_end = int'(it.offset) + int'(it.access_size);
				if (it.access_size != SIZE_1 && it.access_size != SIZE_2 &&
				    it.access_size != SIZE_4)
					r.outcome = OUT_SIZE;
				else if (span_end > lim)
					r.outcome = OUT_RANGE;
				else begin
					for (int i = 0; i < int'(it.access_size); i++) begin
						if (it.cmd == CMD_WRITE)
							dev_bytes[int'(it.offset) + i] = it.write_data[8*i +: 8];
						else
							r.read_data[8*i +: 8] = dev_bytes[int'(it.offset) + i];
					end
				end
			end
			default: r.outcome = OUT_UNSUPPORTED;
		endcase
		if (it.cmd == CMD_WRITE || r.outcome != OUT_OK)
			r.read_data = 32'd0;
		return r;
	endfunction

	function automatic item_t acc(input logic c, input logic [1:0] rg, input logic [7:0] off,
	                              input logic [2:0] sz, input logic [31:0] wd);
		item_t it;
		it.cmd         = c;
		it.region      = rg;
		it.offset      = off;
		it.access_size = sz;
		it.write_data  = wd;
		return it;
	endfunction

	// Mostly well-formed accesses with random content, plus broken widths and raw noise.
	function automatic item_t random_access();
		item_t       it;
		int unsigned pick;
		int unsigned lim;
		pick           = $urandom_range(0, 99);
		lim            = device_window();
		it.cmd         = 1'($urandom_range(0, 1));
		it.region      = REGION_COMMON;
		it.offset      = 8'($urandom_range(0, 255));
		it.access_size = 3'($urandom_range(0, 7));
		it.write_data  = $urandom;
		if (pick < 10) begin
			it.region = 2'($urandom_range(0, 3));
		end else if (pick < 35) begin
			it.region = REGION_DEVICE;
			case ($urandom_range(0, 2))
				0:       it.access_size = SIZE_1;
				1:       it.access_size = SIZE_2;
				default: it.access_size = SIZE_4;
			endcase
			// Stay inside the window most of the time, probe its edge now and then.
			if (lim >= it.access_size && $urandom_range(0, 4) != 0)
				it.offset = 8'($urandom_range(0, lim - it.access_size));
		end else begin
			case ($urandom_range(0, 13))
				0:  it = acc(CMD_READ,  REGION_COMMON, OFF_DEV_FEAT,       SIZE_4, it.write_data);
				1:  it = acc(CMD_READ,  REGION_COMMON, OFF_NUM_QUEUES,     SIZE_2, it.write_data);
				2:  it = acc(CMD_READ,  REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, it.write_data);
				3:  it = acc(CMD_READ,  REGION_COMMON, OFF_CFG_GEN,        SIZE_1, it.write_data);
				4:  it = acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_SIZE,     SIZE_2, it.write_data);
				5:  it = acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_ENABLE,   SIZE_2, it.write_data);
				6:  it = acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_NOTIFY,   SIZE_2, it.write_data);
				7:  it = acc(CMD_WRITE, REGION_COMMON, OFF_DEV_FEAT_SEL,   SIZE_4,
				             $urandom_range(0, 1) ? 32'd0 : it.write_data);
				8:  it = acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT_SEL, SIZE_4,
				             $urandom_range(0, 1) ? 32'd0 : it.write_data);
				9:  it = acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT,     SIZE_4, it.write_data);
				10: it = acc(CMD_WRITE, REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, it.write_data);
				11: it = acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_SEL,      SIZE_2,
				             ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : it.write_data);
				12: it = acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_SIZE,     SIZE_2, it.write_data);
				default:
				    it = acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_ENABLE,   SIZE_2, it.write_data);
			endcase
			// Break the width on a few otherwise valid accesses.
			if ($urandom_range(0, 9) == 0)
				it.access_size = 3'($urandom_range(0, 7));
		end
		return it;
	endfunction

	// Idle cycles before the next item; runs of back-to-back items come in between.
	function automatic int draw_gap();
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			steady_left = $urandom_range(8, 24);
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	// Offer one item, hold it until the block takes it, then log what it must answer.
	task automatic send_access(input item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= it.cmd;
		region      <= it.region;
		offset      <= it.offset;
		access_size <= it.access_size;
		write_data  <= it.write_data;
		// busy read right at the edge is the value the block itself used there
		do @(posedge clk); while (busy !== 1'b0);
		results_due.push_back(apply_access(it));
	endtask

	// Drop start and hold until every owed result has shown up and the pipe is empty.
	task automatic drain_results();
		start <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] idx, input logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_OFFERED_FEATURES: offered_feat = value;
			CFG_QUEUE_COUNT:      queue_cnt    = value[3:0];
			CFG_DEFAULT_QSIZE:    dflt_qsize   = value[15:0];
			default:              dev_cfg_len  = value[8:0];
		endcase
	endtask

	task automatic run_random(input int count);
		repeat (count) send_access(random_access());
	endtask

	// Hand-picked accesses under the reset configuration.
	task automatic test_directed_access();
		// feature halves, with a forced bit visible in each half
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_DEV_FEAT,       SIZE_4, 32'd0));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_DEV_FEAT_SEL,   SIZE_4, 32'hFFFF_FFFF));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_DEV_FEAT,       SIZE_4, 32'd0));
		// accept VERSION_1 only: FEATURES_OK must be refused
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT_SEL, SIZE_4, 32'd1));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT,     SIZE_4, 32'd1));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, 32'hFFFF_FFFF));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, 32'd0));
		// add EVENT_IDX: FEATURES_OK now sticks
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT_SEL, SIZE_4, 32'd0));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_GUEST_FEAT,     SIZE_4, 32'h2000_0000));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, 32'h0000_000B));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, 32'd0));
		// status zero is a plain write, not a device reset
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_DEV_STATUS,     SIZE_1, 32'd0));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_NUM_QUEUES,     SIZE_2, 32'd0));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_CFG_GEN,        SIZE_1, 32'd0));
		// queue 0: default size, then a written size, enable and notify offset
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_SIZE,     SIZE_2, 32'd0));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_SIZE,     SIZE_2, 32'hFFFF_0040));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_SIZE,     SIZE_2, 32'd0));
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_ENABLE,   SIZE_2, 32'd1));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_ENABLE,   SIZE_2, 32'd0));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_NOTIFY,   SIZE_2, 32'd0));
		// select far out of range: queue fields report a bad index
		send_access(acc(CMD_WRITE, REGION_COMMON, OFF_QUEUE_SEL,      SIZE_2, 32'hFFFF_FFFF));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_QUEUE_NOTIFY,   SIZE_2, 32'd0));
		// unknown offset beats a wrong width; wrong width alone
		send_access(acc(CMD_READ,  REGION_COMMON, 8'hFF,              3'd7,   32'd0));
		send_access(acc(CMD_READ,  REGION_COMMON, OFF_DEV_FEAT,       SIZE_2, 32'd0));
		send_access(acc(CMD_WRITE, REGION_NOTIFY, 8'd0,               SIZE_2, 32'hFFFF_FFFF));
		send_access(acc(CMD_READ,  REGION_ISR,    8'd0,               SIZE_1, 32'd0));
		// device store: top word, overrun past the end, odd width
		send_access(acc(CMD_WRITE, REGION_DEVICE, 8'd252,             SIZE_4, 32'hA5C3_0FF1));
		send_access(acc(CMD_READ,  REGION_DEVICE, 8'd252,             SIZE_4, 32'd0));
		send_access(acc(CMD_READ,  REGION_DEVICE, 8'd253,             SIZE_4, 32'd0));
		send_access(acc(CMD_READ,  REGION_DEVICE, 8'd0,               3'd3,   32'd0));
	endtask

	task automatic test_reset_settings();
		run_random(70);
	endtask

	task automatic test_wide_settings();
		drain_results();
		write_config(CFG_OFFERED_FEATURES, {$urandom, $urandom});
		write_config(CFG_QUEUE_COUNT,      64'd8);
		write_config(CFG_DEFAULT_QSIZE,    64'hFFFF);
		write_config(CFG_DEV_CFG_LEN,      64'd256);
		run_random(90);
	endtask

	task automatic test_narrow_settings();
		drain_results();
		write_config(CFG_OFFERED_FEATURES, 64'd0);
		write_config(CFG_QUEUE_COUNT,      64'd1);
		write_config(CFG_DEFAULT_QSIZE,    64'd0);
		write_config(CFG_DEV_CFG_LEN,      64'd0);
		run_random(60);
	endtask

	task automatic test_odd_settings();
		drain_results();
		write_config(CFG_OFFERED_FEATURES, 64'hFFFF_FFFF_FFFF_FFFF);
		write_config(CFG_QUEUE_COUNT,      64'($urandom_range(2, 7)));
		write_config(CFG_DEFAULT_QSIZE,    64'($urandom_range(0, 65535)));
		write_config(CFG_DEV_CFG_LEN,      64'($urandom_range(4, 255)));
		run_random(80);
	endtask

	// Queue count above the queue limit and at zero, store length above the store and at four bytes.
	task automatic test_clamped_settings();
		drain_results();
		write_config(CFG_OFFERED_FEATURES, {$urandom, $urandom});
		write_config(CFG_QUEUE_COUNT,      64'd15);
		write_config(CFG_DEV_CFG_LEN,      64'd511);
		run_random(40);
		drain_results();
		write_config(CFG_QUEUE_COUNT,      64'd0);
		write_config(CFG_DEV_CFG_LEN,      64'd4);
		run_random(40);
	endtask

	// Check each strobed result against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with nothing owed, read_data %h outcome %0d",
				         $time, read_data, outcome);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (read_data !== want.read_data) begin
					$display("%0t: read_data expected %h actual %h",
					         $time, want.read_data, read_data);
					mismatches++;
				end
				if (outcome !== want.outcome) begin
					$display("%0t: outcome expected %0d actual %0d",
					         $time, want.outcome, outcome);
					mismatches++;
				end
			end
		end
	end

	// Stop a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_CAP) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : sequencer
		// mirror starts at the reset state
		offered_feat  = OFFERED_FEATURES_RST;
		queue_cnt     = QUEUE_COUNT_RST;
		dflt_qsize    = DEFAULT_QSIZE_RST;
		dev_cfg_len   = DEV_CFG_LEN_RST;
		dev_feat_hi   = 1'b0;
		guest_feat_hi = 1'b0;
		guest_feat    = 64'd0;
		dev_status    = 8'd0;
		cur_queue     = 16'd0;
		for (int i = 0; i < MAX_Q; i++) begin
			qsize_tab[i]   = 16'd0;
			qsize_set[i]   = 1'b0;
			qenable_tab[i] = 16'd0;
		end
		for (int i = 0; i < CFG_BYTES; i++)
			dev_bytes[i] = 8'd0;

		// hold reset, release on an edge; busy covers the store sweep that follows
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_access();
		test_reset_settings();
		test_wide_settings();
		test_narrow_settings();
		test_odd_settings();
		test_clamped_settings();
		drain_results();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/vpcc_pkg.sv
hdl/vpcc_common.sv
hdl/vpcc_devcfg.sv
hdl/virtio_pci_common_config_regs.sv
bench/tb.sv
